/* rtl/kwmq_pkg.sv */
// Shared types, constants and the ordering function for the k-way merge queue.
// No dependencies; the top level imports everything from here.
`timescale 1ns / 1ps

package kwmq_pkg;

  localparam int unsigned NUM_LISTS = 16;
  localparam int unsigned IDX_W     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned OCC_W     = $clog2(NUM_LISTS + 1);

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_POP  = 1'b1;

  localparam logic [1:0] ST_PUSHED     = 2'd0;
  localparam logic [1:0] ST_POPPED     = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
    logic        [3:0]  list_id;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic        [3:0]  list_out;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [3:0]  list_id;
  } entry_t;

  // smaller value first, lower list number on a tie
  function automatic logic entry_before(input entry_t a, input entry_t b);
    logic lt;
    logic eq;
    lt = $signed(a.value) < $signed(b.value);
    eq = a.value == b.value;
    return lt || (eq && (a.list_id < b.list_id));
  endfunction

endpackage

/* rtl/k_way_merge_min_queue.sv */
// Min-priority queue of {value, list} entries for a k-way merge.
// Entries live in a synchronous RAM with one read and one write port; depends on kwmq_pkg.
`timescale 1ns / 1ps

//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------
//  in      | in_valid_i, in_stall_o, in_item_i  | push or pop item
//  out     | out_valid_o, out_stall_i, out_item_o | one result item per input
//
//  Push, refused push and pop on empty: result registered at accept.
//  Pop: the RAM read port scans one entry a cycle to find the minimum,
//  then the last entry is written into the freed slot.
//  Reset clears occupancy and control only; RAM contents need no clearing.
//  A stalled output holds its item and stalls the input until it is taken;
//  a finished pop waits in the write-back state for the output to free up.

module k_way_merge_min_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kwmq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kwmq_pkg::out_item_t out_item_o
);
  import kwmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  entry_t             best_q, best_d;
  entry_t             last_q, last_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  entry_t             mem [NUM_LISTS];
  entry_t             rd_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic               can_load;
  logic               accept;
  logic               full;
  logic               scan_last;
  logic               take;

  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !can_load;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = occ_q >= OCC_W'(NUM_LISTS);
  assign scan_last  = {1'b0, cnt_q} == (occ_q - OCC_W'(1));
  assign take       = (cnt_q == '0) || entry_before(rd_q, best_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = occ_q[IDX_W-1:0];
    wr_data     = '{value: in_item_i.value, list_id: in_item_i.list_id};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_item_d = '{value_out: '0, list_out: '0, status: ST_PUSHED};
          if (in_item_i.opcode == OP_PUSH) begin
            out_valid_d = 1'b1;
            if (full) begin
              out_item_d.status = ST_FULL;
            end else begin
              wr_en = 1'b1;
              occ_d = occ_q + OCC_W'(1);
            end
          end else if (occ_q == '0) begin
            out_valid_d       = 1'b1;
            out_item_d.status = ST_EMPTY;
          end else begin
            cnt_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = cnt_q + IDX_W'(1);
        if (take) begin
          best_d     = rd_q;
          best_idx_d = cnt_q;
        end
        cnt_d = cnt_q + IDX_W'(1);
        if (scan_last) begin
          last_d  = rd_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (can_load) begin
          wr_en       = 1'b1;
          wr_addr     = best_idx_q;
          wr_data     = last_q;
          occ_d       = occ_q - OCC_W'(1);
          out_valid_d = 1'b1;
          out_item_d  = '{value_out: best_q.value, list_out: best_q.list_id,
                          status: ST_POPPED};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    last_q     <= last_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(NUM_LISTS))
    else $error("occupancy above capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> {1'b0, cnt_q} < occ_q)
    else $error("scan index past occupancy");

  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_DONE) || (state_q == S_IDLE && accept))
    else $error("RAM write outside push or pop write-back");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && can_load |=> occ_q == $past(occ_q) - OCC_W'(1))
    else $error("pop did not free one entry");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && can_load |=> out_valid_q && out_item_q.status == ST_POPPED)
    else $error("pop result not presented");

endmodule

/* test/k_way_merge_min_queue_test.sv */
// Testbench for k_way_merge_min_queue: random-gap driver, random-stall receiver,
// and an in-bench min-queue predictor checked against every result item.
// Depends on kwmq_pkg and the k_way_merge_min_queue RTL.
`timescale 1ns / 1ps

module k_way_merge_min_queue_test;
  import kwmq_pkg::*;

  localparam int ITEMS   = 2000;
  localparam int MAX_RUN = 6;

  typedef struct {
    in_item_t item;
    bit       settle;
  } stim_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  stim_t     stim[$];
  out_item_t results_due[$];

  logic signed [31:0] held_val [NUM_LISTS];
  logic        [3:0]  held_lst [NUM_LISTS];
  int unsigned        held_cnt = 0;

  bit in_taken   = 1'b0;
  bit out_taken  = 1'b0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int in_gap     = 0;
  int out_wait   = 0;
  int hold_left  = 0;
  int holds_done = 0;
  int rcv_draw   = 0;
  int n_accepted = 0;
  int n_pushed   = 0;
  int n_popped   = 0;
  int n_empty    = 0;
  int n_full     = 0;
  int n_merges   = 0;
  int errors     = 0;

  k_way_merge_min_queue u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #1 clk = ~clk;

  function automatic out_item_t minq_apply(input in_item_t it);
    out_item_t   r;
    int unsigned best;
    int unsigned i;
    r = '0;
    if (it.opcode == OP_PUSH) begin
      if (held_cnt >= NUM_LISTS) begin
        r.status = ST_FULL;
      end else begin
        held_val[held_cnt] = it.value;
        held_lst[held_cnt] = it.list_id;
        held_cnt++;
        r.status = ST_PUSHED;
      end
    end else if (held_cnt == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (i = 1; i < held_cnt; i++) begin
        if (held_val[i] < held_val[best] ||
            (held_val[i] == held_val[best] && held_lst[i] < held_lst[best])) begin
          best = i;
        end
      end
      r.value_out = held_val[best];
      r.list_out  = held_lst[best];
      r.status    = ST_POPPED;
      held_cnt--;
      held_val[best] = held_val[held_cnt];
      held_lst[best] = held_lst[held_cnt];
    end
    return r;
  endfunction

  task automatic add_item(input logic op, input logic signed [31:0] v,
                          input logic [3:0] lst, input bit settle);
    stim_t s;
    s.item.opcode  = op;
    s.item.value   = v;
    s.item.list_id = lst;
    s.settle       = settle;
    stim.push_back(s);
  endtask

  task automatic add_drain();
    repeat (NUM_LISTS + 1) add_item(OP_POP, $urandom, 4'($urandom), 1'b0);
  endtask

  task automatic add_noise(input int push_pct, input int count);
    repeat (count) begin
      add_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
               $urandom, 4'($urandom), 1'b0);
    end
  endtask

  task automatic add_fill(input bit settle);
    add_item(OP_PUSH, $urandom, 4'($urandom), settle);
    repeat ($urandom_range(NUM_LISTS, NUM_LISTS + 4)) begin
      add_item(OP_PUSH, $urandom, 4'($urandom), 1'b0);
    end
    add_drain();
  endtask

  // Well-formed merge: push every list head, then pop and push the successor
  // from the returned list. A broken merge stops early and falls into noise.
  task automatic add_merge(input bit narrow, input bit broken, input bit settle);
    logic signed [31:0] lv [NUM_LISTS][MAX_RUN];
    int     run_len [NUM_LISTS];
    int     nxt [NUM_LISTS];
    bit     live [NUM_LISTS];
    longint acc;
    int     best, cut, steps, off, l, j;
    bit     first;
    first = settle;
    cut   = broken ? $urandom_range(1, 40) : -1;
    off   = $urandom_range(0, NUM_LISTS - 1);
    for (l = 0; l < NUM_LISTS; l++) begin
      run_len[l] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_RUN);
      nxt[l]     = 0;
      live[l]    = 1'b0;
      acc = narrow ? longint'($urandom_range(0, 4)) - 2 : longint'($signed($urandom));
      for (j = 0; j < MAX_RUN; j++) begin
        lv[l][j] = acc[31:0];
        acc += narrow ? $urandom_range(0, 1) : $urandom_range(0, 32'h0800_0000);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      end
    end
    for (j = 0; j < NUM_LISTS; j++) begin
      l = (j + off) % NUM_LISTS;
      if (run_len[l] != 0) begin
        add_item(OP_PUSH, lv[l][0], l[3:0], first);
        first   = 1'b0;
        nxt[l]  = 1;
        live[l] = 1'b1;
      end
    end
    steps = 0;
    best  = 0;
    while (best >= 0 && steps != cut) begin
      best = -1;
      for (l = 0; l < NUM_LISTS; l++) begin
        if (live[l] && (best < 0 || lv[l][nxt[l] - 1] < lv[best][nxt[best] - 1])) best = l;
      end
      if (best >= 0) begin
        add_item(OP_POP, $urandom, 4'($urandom), 1'b0);
        live[best] = 1'b0;
        if (nxt[best] < run_len[best]) begin
          add_item(OP_PUSH, lv[best][nxt[best]], best[3:0], 1'b0);
          nxt[best]++;
          live[best] = 1'b1;
        end
        steps++;
      end
    end
    if (broken) begin
      add_noise($urandom_range(20, 80), $urandom_range(4, 20));
      add_drain();
    end else if ($urandom_range(0, 3) == 0) begin
      add_item(OP_POP, $urandom, 4'($urandom), 1'b0);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (stim.size() != 0 && !(stim[0].settle && results_due.size() != 0)) begin
          in_item  <= stim[0].item;
          in_valid <= 1'b1;
          in_gap   <= send_burst ? 0 : $urandom_range(0, 13);
          if ($urandom_range(0, 63) == 0) send_burst <= !send_burst;
          stim.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && n_accepted >= 600 + 800 * holds_done) begin
        out_stall  <= 1'b1;
        hold_left  <= 250;
        holds_done <= holds_done + 1;
      end else if (out_taken) begin
        rcv_draw = recv_burst ? 0 : $urandom_range(0, 13);
        out_stall <= (rcv_draw != 0);
        out_wait  <= (rcv_draw != 0) ? rcv_draw - 1 : 0;
        if ($urandom_range(0, 63) == 0) recv_burst <= !recv_burst;
      end else if (out_wait != 0) begin
        out_stall <= 1'b1;
        out_wait  <= out_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    if (in_valid && !in_stall) begin
      results_due.push_back(minq_apply(in_item));
      n_accepted++;
    end
    if (out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result value %0d list %0d status %0d", $time,
                 out_item.value_out, out_item.list_out, out_item.status);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (out_item.value_out !== want.value_out) begin
          $display("%0t: value_out expected %0d actual %0d", $time,
                   want.value_out, out_item.value_out);
          errors++;
        end
        if (out_item.list_out !== want.list_out) begin
          $display("%0t: list_out expected %0d actual %0d", $time,
                   want.list_out, out_item.list_out);
          errors++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_item.status);
          errors++;
        end
        unique case (want.status)
          ST_PUSHED: n_pushed++;
          ST_POPPED: n_popped++;
          ST_EMPTY:  n_empty++;
          default:   n_full++;
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int r;
    int seq_no;
    add_item(OP_POP, '1, '1, 1'b0);
    add_item(OP_PUSH, 32'h7fff_ffff, 4'd15, 1'b0);
    add_item(OP_PUSH, 32'h8000_0000, 4'd0, 1'b0);
    add_item(OP_PUSH, 32'h0000_0000, 4'd7, 1'b0);
    add_item(OP_PUSH, 32'hffff_ffff, 4'd8, 1'b0);
    add_item(OP_PUSH, 32'd5, 4'd9, 1'b0);
    add_item(OP_PUSH, 32'd5, 4'd2, 1'b0);
    add_item(OP_PUSH, 32'd5, 4'd2, 1'b0);
    add_item(OP_PUSH, 32'h8000_0001, 4'd4, 1'b0);
    add_item(OP_PUSH, 32'h7fff_ffff, 4'd1, 1'b0);
    repeat (10) add_item(OP_POP, $urandom, 4'($urandom), 1'b0);
    add_fill(1'b1);
    seq_no = 0;
    while (stim.size() < ITEMS) begin
      r = $urandom_range(0, 9);
      seq_no++;
      if (r <= 6) begin
        add_merge(r < 3, r == 2 || r == 6, seq_no % 8 == 3);
        n_merges++;
      end else if (r <= 8) begin
        add_noise($urandom_range(30, 90), $urandom_range(10, 40));
        add_drain();
      end else begin
        add_fill(seq_no % 8 == 3);
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (stim.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Ran %0d items in %0d merge runs plus noise and fill runs,", n_accepted, n_merges);
    $display("  %0d pushes, %0d pops, %0d empty pops, %0d refused pushes.",
             n_pushed, n_popped, n_empty, n_full);
    if (errors == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
